// ===== sv/text_line_ending_converter_unit_assert.svh =====
// Assertion macros for the line ending converter
`ifndef TEXT_LINE_ENDING_CONVERTER_UNIT_ASSERT_SVH
`define TEXT_LINE_ENDING_CONVERTER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Property holds in every cycle out of reset
`define TLEC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Antecedent implies consequent in the same cycle
`define TLEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Antecedent implies consequent in the next cycle
`define TLEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TLEC_ASSERT(lbl, clk, rst_n, prop)
`define TLEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TLEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/tlec_pkg.sv =====
package tlec_pkg;

  // Character codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NONTEXT = 2'd1;
  localparam logic [1:0] ST_TOOLONG = 2'd2;

  // Line ending modes (any other code means LF only)
  localparam logic [1:0] MODE_CRLF = 2'd0;
  localparam logic [1:0] MODE_CR   = 2'd1;
  localparam logic [1:0] MODE_LF   = 2'd2;

  // Configuration register map
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned LIMIT_W    = 11;
  localparam logic REG_EOL_MODE   = 1'b0;
  localparam logic REG_LINE_LIMIT = 1'b1;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 11'd1024;

  // Work handed from front to back
  typedef enum logic [1:0] {
    JOB_EOL  = 2'd0,
    JOB_TEXT = 2'd1,
    JOB_ERR  = 2'd2
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] data;
    logic [1:0] status;
  } job_t;

endpackage

// ===== sv/tlec_front.sv =====
module tlec_front import tlec_pkg::*; #(
  parameter int MAX_LINE_LEN = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [7:0]         in_byte_i,
  input  logic               file_start_i,
  input  logic [LIMIT_W-1:0] line_limit_i,
  input  logic               q_full_i,
  output logic               q_wr_o,
  output job_t               q_job_o
);

  localparam int LimMax = (MAX_LINE_LEN < 2047) ? MAX_LINE_LEN : 2047;
  localparam int CntW   = $clog2(LimMax + 1);
  localparam logic [LIMIT_W-1:0] LimMaxV = LIMIT_W'(LimMax);

  logic            cr_q, cr_d;
  logic            halt_q, halt_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic               accept;
  logic               cr_eff, halt_eff, is_text;
  logic [CntW-1:0]    cnt_eff;
  logic [LIMIT_W-1:0] limit;

  assign accept  = push_i && !q_full_i;
  assign is_text = (in_byte_i == CH_TAB) || ((in_byte_i >= CH_SPACE) && (in_byte_i <= CH_TILDE));
  assign limit   = (line_limit_i > LimMaxV) ? LimMaxV : line_limit_i;

  // A new file clears line state before its first byte is handled
  assign cr_eff   = file_start_i ? 1'b0 : cr_q;
  assign halt_eff = file_start_i ? 1'b0 : halt_q;
  assign cnt_eff  = file_start_i ? '0 : cnt_q;

  // Classify the byte and decide what the back end must emit
  always_comb begin
    cr_d    = cr_q;
    halt_d  = halt_q;
    cnt_d   = cnt_q;
    q_wr_o  = 1'b0;
    q_job_o = '{kind: JOB_TEXT, data: in_byte_i, status: ST_OK};
    if (accept) begin
      cr_d   = cr_eff;
      halt_d = halt_eff;
      cnt_d  = cnt_eff;
      if (!halt_eff) begin
        if (in_byte_i == CH_CR) begin
          cr_d    = 1'b1;
          cnt_d   = '0;
          q_wr_o  = 1'b1;
          q_job_o = '{kind: JOB_EOL, data: in_byte_i, status: ST_OK};
        end else if (in_byte_i == CH_LF) begin
          if (cr_eff) begin
            // drop the LF of a CR-LF pair
            cr_d = 1'b0;
          end else begin
            cnt_d   = '0;
            q_wr_o  = 1'b1;
            q_job_o = '{kind: JOB_EOL, data: in_byte_i, status: ST_OK};
          end
        end else begin
          cr_d   = 1'b0;
          q_wr_o = 1'b1;
          if (!is_text) begin
            halt_d  = 1'b1;
            q_job_o = '{kind: JOB_ERR, data: 8'h00, status: ST_NONTEXT};
          end else if (LIMIT_W'(cnt_eff) >= limit) begin
            halt_d  = 1'b1;
            q_job_o = '{kind: JOB_ERR, data: 8'h00, status: ST_TOOLONG};
          end else begin
            cnt_d   = cnt_eff + CntW'(1);
            q_job_o = '{kind: JOB_TEXT, data: in_byte_i, status: ST_OK};
          end
        end
      end
    end
  end

  // Hold line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_q   <= 1'b0;
      halt_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      cr_q   <= cr_d;
      halt_q <= halt_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== sv/tlec_queue.sv =====
module tlec_queue import tlec_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  job_t wr_job_i,
  input  logic rd_i,
  output job_t rd_job_o,
  output logic full_o,
  output logic empty_o
);

  job_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  logic       do_wr, do_rd;

  assign full_o   = (count_q == 2'd2);
  assign empty_o  = (count_q == 2'd0);
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && !empty_o;
  assign rd_job_o = mem_q[rptr_q];

  // Store requests
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_job_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_wr) begin
        wptr_q <= ~wptr_q;
      end
      if (do_rd) begin
        rptr_q <= ~rptr_q;
      end
      count_q <= count_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

// ===== sv/tlec_back.sv =====
`include "text_line_ending_converter_unit_assert.svh"

module tlec_back import tlec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] eol_mode_i,
  input  logic       q_empty_i,
  input  job_t       q_job_i,
  output logic       q_rd_o,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  output logic       run_last_o
);

  logic       valid_q, valid_d;
  logic       lf_due_q, lf_due_d;
  logic [7:0] byte_q, byte_d;
  logic [1:0] stat_q, stat_d;
  logic       last_q, last_d;
  logic       load;

  // The output register may take a new result when free or being drained
  assign load   = !valid_q || pop;
  assign q_rd_o = load && !lf_due_q && !q_empty_i;

  // Expand one request into one or two results
  always_comb begin
    valid_d  = valid_q;
    lf_due_d = lf_due_q;
    byte_d   = byte_q;
    stat_d   = stat_q;
    last_d   = last_q;
    if (load) begin
      if (lf_due_q) begin
        valid_d  = 1'b1;
        lf_due_d = 1'b0;
        byte_d   = CH_LF;
        stat_d   = ST_OK;
        last_d   = 1'b1;
      end else if (!q_empty_i) begin
        valid_d = 1'b1;
        stat_d  = q_job_i.status;
        last_d  = 1'b1;
        case (q_job_i.kind)
          JOB_EOL: begin
            stat_d = ST_OK;
            if (eol_mode_i == MODE_CRLF) begin
              byte_d   = CH_CR;
              last_d   = 1'b0;
              lf_due_d = 1'b1;
            end else if (eol_mode_i == MODE_CR) begin
              byte_d = CH_CR;
            end else begin
              byte_d = CH_LF;
            end
          end
          JOB_TEXT: byte_d = q_job_i.data;
          JOB_ERR:  byte_d = 8'h00;
          default:  byte_d = 8'h00;
        endcase
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      lf_due_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      lf_due_q <= lf_due_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    stat_q <= stat_d;
    last_q <= last_d;
  end

  assign empty      = !valid_q;
  assign out_byte_o = byte_q;
  assign status_o   = stat_q;
  assign run_last_o = last_q;

  // A pending LF always follows a CR shown as the first half of the pair
  `TLEC_ASSERT_IMP(a_lf_due_after_cr, clk_i, rst_ni, lf_due_q,
    valid_q && (byte_q == CH_CR) && !last_q)
  // Error results carry a zero byte and close their run
  `TLEC_ASSERT_IMP(a_err_zero, clk_i, rst_ni, valid_q && (stat_q != ST_OK),
    (byte_q == 8'h00) && last_q)
  // A result that is not taken is never dropped
  `TLEC_ASSERT_NXT(a_no_drop, clk_i, rst_ni, valid_q && !pop, valid_q)

endmodule

// ===== sv/text_line_ending_converter_unit.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------
// input    | push / full          | in_byte_i[7:0], file_start_i
// result   | empty / pop          | out_byte_o[7:0], status_o[1:0], run_last_o
// config   | cfg_we_i, cfg_idx_i  | cfg_data_i[10:0]
//
// One byte is accepted per cycle while full is low; the queue holds two requests.
// A line end in CR-LF mode gives two results, which pass through the output register
// in turn; the output side gives one result per cycle while results are popped.
// A byte's result is registered in the queue and then in the output register.
// Reset is asynchronous and active low; no clearing pass is needed.
// Each side may stall freely; full rises only when the two-entry queue is full.
module text_line_ending_converter_unit import tlec_pkg::*; #(
  parameter int MAX_LINE_LEN = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            in_byte_i,
  input  logic                  file_start_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            out_byte_o,
  output logic [1:0]            status_o,
  output logic                  run_last_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [1:0]         eol_mode_q;
  logic [LIMIT_W-1:0] line_limit_q;

  logic q_wr, q_rd, q_full, q_empty;
  job_t wr_job, rd_job;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eol_mode_q   <= MODE_LF;
      line_limit_q <= LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_EOL_MODE:   eol_mode_q   <= cfg_data_i[1:0];
        REG_LINE_LIMIT: line_limit_q <= cfg_data_i[LIMIT_W-1:0];
        default:        ;
      endcase
    end
  end

  assign full = q_full;

  tlec_front #(
    .MAX_LINE_LEN(MAX_LINE_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_byte_i   (in_byte_i),
    .file_start_i(file_start_i),
    .line_limit_i(line_limit_q),
    .q_full_i    (q_full),
    .q_wr_o      (q_wr),
    .q_job_o     (wr_job)
  );

  tlec_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wr_job_i(wr_job),
    .rd_i    (q_rd),
    .rd_job_o(rd_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  tlec_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .eol_mode_i(eol_mode_q),
    .q_empty_i (q_empty),
    .q_job_i   (rd_job),
    .q_rd_o    (q_rd),
    .pop       (pop),
    .empty     (empty),
    .out_byte_o(out_byte_o),
    .status_o  (status_o),
    .run_last_o(run_last_o)
  );

endmodule

// ===== test/tb_text_line_ending_converter_unit.sv =====
`timescale 1ns / 100ps

import tlec_pkg::*;

// One converted byte as it leaves the block
typedef struct packed {
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       run_last;
} conv_result_t;

// Predict converted bytes and match them against the block's output
class line_end_scoreboard;
  conv_result_t expected_chars[$];
  logic [1:0]   eol_mode;
  logic [10:0]  line_limit;
  logic         cr_pending;
  logic [10:0]  line_count;
  logic         halted;
  int           fail_count;
  int           max_len;

  function new(int max_len_val);
    max_len    = max_len_val;
    eol_mode   = MODE_LF;
    line_limit = LIMIT_RST;
    cr_pending = 1'b0;
    line_count = '0;
    halted     = 1'b0;
    fail_count = 0;
  endfunction

  function void set_config(logic [10:0] mode_data, logic [10:0] limit_data);
    eol_mode   = mode_data[1:0];
    line_limit = limit_data;
  endfunction

  function void add_char(logic [7:0] b, logic [1:0] st, logic last);
    conv_result_t r;
    r.out_byte = b;
    r.status   = st;
    r.run_last = last;
    expected_chars.push_back(r);
  endfunction

  // Queue the line end in the configured form; unused mode means LF only
  function void add_line_end();
    if (eol_mode == MODE_CRLF) begin
      add_char(CH_CR, ST_OK, 1'b0);
      add_char(CH_LF, ST_OK, 1'b1);
    end else if (eol_mode == MODE_CR) begin
      add_char(CH_CR, ST_OK, 1'b1);
    end else begin
      add_char(CH_LF, ST_OK, 1'b1);
    end
  endfunction

  // Note an accepted request; return 1 unless the block ignores it
  function bit note_byte(logic [7:0] b, logic fs);
    logic [10:0] limit;
    if (fs) begin
      cr_pending = 1'b0;
      line_count = '0;
      halted     = 1'b0;
    end
    if (halted) return 1'b0;
    if (b == CH_CR) begin
      cr_pending = 1'b1;
      line_count = '0;
      add_line_end();
      return 1'b1;
    end
    if (b == CH_LF) begin
      // LF right after CR closes nothing new
      if (cr_pending) begin
        cr_pending = 1'b0;
        return 1'b1;
      end
      line_count = '0;
      add_line_end();
      return 1'b1;
    end
    cr_pending = 1'b0;
    // Non-text wins over line length and does not count
    if (!(b == CH_TAB || (b >= CH_SPACE && b <= CH_TILDE))) begin
      halted = 1'b1;
      add_char(8'h00, ST_NONTEXT, 1'b1);
      return 1'b1;
    end
    limit = (line_limit > max_len) ? 11'(max_len) : line_limit;
    if (line_count >= limit) begin
      halted = 1'b1;
      add_char(8'h00, ST_TOOLONG, 1'b1);
      return 1'b1;
    end
    line_count++;
    add_char(b, ST_OK, 1'b1);
    return 1'b1;
  endfunction

  // Compare one popped result with the oldest expectation
  function void check_output(logic [7:0] ob, logic [1:0] st, logic rl);
    conv_result_t want;
    if (expected_chars.size() == 0) begin
      $display("%0t: unexpected result out_byte %h status %0d run_last %b",
               $time, ob, st, rl);
      fail_count++;
      return;
    end
    want = expected_chars.pop_front();
    if (ob !== want.out_byte) begin
      $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, ob);
      fail_count++;
    end
    if (st !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, st);
      fail_count++;
    end
    if (rl !== want.run_last) begin
      $display("%0t: run_last expected %b actual %b", $time, want.run_last, rl);
      fail_count++;
    end
  endfunction

  function int pending();
    return expected_chars.size();
  endfunction
endclass

module tb_text_line_ending_converter_unit;

  localparam int         LINE_LEN_MAX = 1024;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  push         = 1'b0;
  logic                  full;
  logic [7:0]            in_byte_i    = '0;
  logic                  file_start_i = 1'b0;
  logic                  empty;
  logic                  pop          = 1'b0;
  logic [7:0]            out_byte_o;
  logic [1:0]            status_o;
  logic                  run_last_o;
  logic                  cfg_we_i     = 1'b0;
  logic                  cfg_idx_i    = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;

  line_end_scoreboard sb;

  int   snd_idle_pct  = 0;
  int   rcv_stall_pct = 0;
  int   live_items    = 0;
  logic new_file      = 1'b0;

  text_line_ending_converter_unit #(
    .MAX_LINE_LEN(LINE_LEN_MAX)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_byte_i   (in_byte_i),
    .file_start_i(file_start_i),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .run_last_o  (run_last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Pop results with random stalls and check each one taken
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_output(out_byte_o, status_o, run_last_o);
    pop <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // Offer one byte after a random gap and hold it until accepted
  task automatic send(input logic [7:0] b, input logic fs);
    int gap;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push         <= 1'b1;
    in_byte_i    <= b;
    file_start_i <= fs;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (sb.note_byte(b, fs)) live_items++;
  endtask

  // Send a byte, marking it as a file start when one is due
  task automatic send_next(input logic [7:0] b);
    send(b, new_file);
    new_file = 1'b0;
  endtask

  // Drop push, drain all results, then let ignored bytes settle
  task automatic wait_idle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write both registers on consecutive edges
  task automatic write_config(input logic [1:0] mode, input logic [10:0] limit);
    logic [10:0] mode_data;
    mode_data = {11'($urandom_range(0, 511)) << 2} | 11'(mode);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_EOL_MODE;
    cfg_data_i <= mode_data;
    @(posedge clk_i);
    cfg_idx_i  <= REG_LINE_LIMIT;
    cfg_data_i <= limit;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_config(mode_data, limit);
  endtask

  function automatic logic [7:0] random_char();
    int r;
    r = $urandom_range(0, 199);
    if (r == 0) return 8'($urandom_range(0, 255));
    if (r < 12) return CH_TAB;
    return 8'($urandom_range(CH_SPACE, CH_TILDE));
  endfunction

  // Send whole files of random lines until enough bytes have been handled
  task automatic send_files(input int n_live, input int lim);
    int start_cnt;
    int len;
    int kind;
    int cap;
    start_cnt = live_items;
    while (live_items - start_cnt < n_live) begin
      new_file = 1'b1;
      repeat ($urandom_range(1, 4)) begin
        cap = (lim <= 20) ? lim + 1 : 30;
        len = $urandom_range(0, cap);
        repeat (len) send_next(random_char());
        kind = $urandom_range(0, 11);
        if (kind < 3) begin
          send_next(CH_CR);
        end else if (kind < 6) begin
          send_next(CH_LF);
        end else if (kind < 9) begin
          send_next(CH_CR);
          send_next(CH_LF);
        end else if (kind == 10) begin
          send_next(CH_LF);
          send_next(CH_CR);
        end else if (kind == 11) begin
          send_next(CH_CR);
          send_next(CH_CR);
        end
      end
    end
  endtask

  // Reconfigure while idle, set the idling mix, then run random files
  task automatic run_phase(input logic [1:0] mode, input logic [10:0] limit,
                           input int snd, input int rcv, input int n_live);
    wait_idle();
    write_config(mode, limit);
    snd_idle_pct  = snd;
    rcv_stall_pct = rcv;
    send_files(n_live, limit);
  endtask

  initial begin
    sb = new(LINE_LEN_MAX);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: LF only, full limit
    send(8'h41, 1'b0);
    send(CH_TAB, 1'b0);
    send(CH_SPACE, 1'b0);
    send(CH_TILDE, 1'b0);
    send(CH_CR, 1'b0);
    send(CH_LF, 1'b0);
    send(CH_LF, 1'b0);
    send(8'h7F, 1'b0);
    send(8'h41, 1'b0);
    send(8'h00, 1'b1);
    send(CH_CR, 1'b1);

    // CR-LF output with a two byte limit; overflow, then both faults at once
    wait_idle();
    write_config(MODE_CRLF, 11'd2);
    send(8'h61, 1'b1);
    send(8'h62, 1'b0);
    send(8'h63, 1'b0);
    send(8'h64, 1'b0);
    send(8'h78, 1'b1);
    send(8'h79, 1'b0);
    send(8'h80, 1'b0);
    send(CH_CR, 1'b1);
    send(CH_LF, 1'b0);

    // CR only with zero limit; file start clears a pending CR
    wait_idle();
    write_config(MODE_CR, 11'd0);
    send(8'h7A, 1'b1);
    send(CH_CR, 1'b1);
    send(CH_LF, 1'b1);

    // Unused mode code acts as LF only
    wait_idle();
    write_config(MODE_UNUSED, 11'd1);
    send(8'h71, 1'b1);
    send(CH_LF, 1'b0);
    send(8'h72, 1'b0);
    send(8'hFF, 1'b0);

    // Random files across settings and idling mixes
    run_phase(MODE_CRLF, 11'd1, 0, 0, 120);
    run_phase(MODE_CR, 11'($urandom_range(2, 12)), 53, 0, 120);
    run_phase(MODE_LF, 11'd1024, 0, 53, 120);
    run_phase(MODE_UNUSED, 11'($urandom_range(3, 20)), 35, 35, 120);

    // Limit above the maximum clamps to it: one full line, then overflow
    wait_idle();
    write_config(MODE_CRLF, 11'd2047);
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    send(random_char() | 8'h20, 1'b1);
    repeat (LINE_LEN_MAX) send(8'($urandom_range(CH_SPACE, CH_TILDE)), 1'b0);
    send(8'h5A, 1'b0);
    send(CH_CR, 1'b1);
    send_files(60, 2047);

    run_phase(2'($urandom_range(0, 3)), 11'($urandom_range(1, 16)), 35, 35, 120);
    run_phase(MODE_CRLF, 11'd5, 0, 53, 110);
    run_phase(MODE_CR, 11'd1024, 53, 0, 110);

    // Drain everything and watch for stray results
    push <= 1'b0;
    rcv_stall_pct = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/tlec_pkg.sv
sv/tlec_front.sv
sv/tlec_queue.sv
sv/tlec_back.sv
sv/text_line_ending_converter_unit.sv
test/tb_text_line_ending_converter_unit.sv
